/* rtl/core/sfe_pkg.sv */
// Shared types, codes and the CRC-8/SMBUS byte update for the sample frame encoder.
// No dependencies; every other file of the encoder except sfe_checker imports this package.
`default_nettype none

package sfe_pkg;

	// input item kinds, carried on s_tuser
	localparam logic ITEM_START  = 1'b0;
	localparam logic ITEM_SAMPLE = 1'b1;

	// configuration register indexes (byte address 4 * index)
	localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] REG_FRAME_TYPE  = 2'd2;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
	localparam logic [7:0] FRAME_TYPE_RST  = 8'h01;

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_INIT = 8'h00;

	// byte positions within a header job and a data job
	localparam logic [2:0] HDR_SYNC1  = 3'd0;
	localparam logic [2:0] HDR_SYNC2  = 3'd1;
	localparam logic [2:0] HDR_TYPE   = 3'd2;
	localparam logic [2:0] HDR_LEN_LO = 3'd3;
	localparam logic [2:0] HDR_LEN_HI = 3'd4;
	localparam logic [2:0] HDR_SEQ    = 3'd5;
	localparam logic [2:0] HDR_CRC    = 3'd6;
	localparam logic [2:0] DAT_LO     = 3'd0;
	localparam logic [2:0] DAT_HI     = 3'd1;
	localparam logic [2:0] DAT_CRC    = 3'd2;

	localparam int QUEUE_DEPTH = 2;

	// one job handed from the front end to the byte serialiser
	typedef struct packed {
		logic        is_hdr;   // header job, else two data bytes
		logic        with_crc; // close the frame with its CRC byte
		logic [7:0]  seq;      // sequence byte (header jobs)
		logic [15:0] word;     // length in bytes (header) or sample (data)
	} sfe_cmd_t;

	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
		logic [7:0] frame_type;
	} sfe_cfg_t;

	// fold one byte into a CRC-8/SMBUS value, msb first
	function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/sfe_regs.sv */
// APB-style configuration registers: sync bytes and frame type.
// Depends on sfe_pkg for register indexes, reset values and sfe_cfg_t.
`default_nettype none

module sfe_regs (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [3:0]      paddr,
	input  wire logic [31:0]     pwdata,
	output logic      [31:0]     prdata,
	output logic                 pready,
	output sfe_pkg::sfe_cfg_t    cfg
);
	import sfe_pkg::*;

	sfe_cfg_t cfg_q;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= SYNC_FIRST_RST;
			cfg_q.sync_second <= SYNC_SECOND_RST;
			cfg_q.frame_type  <= FRAME_TYPE_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_SYNC_FIRST:  cfg_q.sync_first  <= pwdata[7:0];
				REG_SYNC_SECOND: cfg_q.sync_second <= pwdata[7:0];
				REG_FRAME_TYPE:  cfg_q.frame_type  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[3:2])
			REG_SYNC_FIRST:  prdata = {24'd0, cfg_q.sync_first};
			REG_SYNC_SECOND: prdata = {24'd0, cfg_q.sync_second};
			REG_FRAME_TYPE:  prdata = {24'd0, cfg_q.frame_type};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/sfe_front.sv */
// Front end: accepts start and sample items, tracks the open frame and posts jobs.
// Depends on sfe_pkg for command codes and sfe_cmd_t.
`default_nettype none

module sfe_front #(
	parameter int MAX_SAMPLES = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [31:0]        s_tdata,
	input  wire logic               s_tuser,
	input  wire logic               q_full,
	output logic                    push,
	output sfe_pkg::sfe_cmd_t       push_data
);
	import sfe_pkg::*;

	logic [15:0] samples_left_q;
	logic        dropping_q;
	logic [7:0]  seq_q;

	logic [15:0] count;
	logic [15:0] sample;
	logic        accept;
	logic        too_big;
	logic        last_sample;

	assign count       = s_tdata[15:0];
	assign sample      = s_tdata[31:16];
	assign s_tready    = !q_full;
	assign accept      = s_tvalid && s_tready;
	assign too_big     = count > 16'(MAX_SAMPLES);
	assign last_sample = samples_left_q == 16'd1;

	// classify the item and build its job
	always_comb begin
		push      = 1'b0;
		push_data = '0;
		if (s_tuser == ITEM_START) begin
			push_data.is_hdr   = 1'b1;
			push_data.with_crc = count == 16'd0;
			push_data.seq      = seq_q;
			push_data.word     = {count[14:0], 1'b0};
			push               = accept && !too_big;
		end else begin
			push_data.is_hdr   = 1'b0;
			push_data.with_crc = last_sample;
			push_data.word     = sample;
			push               = accept && samples_left_q != 16'd0 && !dropping_q;
		end
	end

	// advance frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_left_q <= 16'd0;
			dropping_q     <= 1'b0;
			seq_q          <= 8'd0;
		end else if (accept) begin
			if (s_tuser == ITEM_START) begin
				samples_left_q <= count;
				dropping_q     <= too_big;
				if (!too_big) begin
					seq_q <= seq_q + 8'd1;
				end
			end else if (samples_left_q != 16'd0) begin
				samples_left_q <= samples_left_q - 16'd1;
				if (last_sample) begin
					dropping_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sfe_queue.sv */
// Short job queue between the front end and the byte serialiser.
// Depends on sfe_pkg for sfe_cmd_t and QUEUE_DEPTH.
`default_nettype none

module sfe_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  sfe_pkg::sfe_cmd_t       push_data,
	output logic                    full,
	input  wire logic               pop,
	output logic                    head_valid,
	output sfe_pkg::sfe_cmd_t       head
);
	import sfe_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	sfe_cmd_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// move pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sfe_back.sv */
// Back end: serialises queued jobs into frame bytes, keeps the running CRC.
// Depends on sfe_pkg for byte positions, crc8_add, sfe_cmd_t and sfe_cfg_t.
`default_nettype none

module sfe_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               head_valid,
	input  sfe_pkg::sfe_cmd_t       head,
	output logic                    pop,
	input  sfe_pkg::sfe_cfg_t       cfg,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [7:0]              m_tdata,
	output logic                    m_tlast,
	output logic                    m_tuser
);
	import sfe_pkg::*;

	logic [2:0] idx_q;
	logic [7:0] crc_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_frame_end_q;
	logic       out_run_end_q;

	logic [2:0] last_idx;
	logic [7:0] cur_byte;
	logic       cur_crc;
	logic       covered;
	logic       load;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_frame_end_q;
	assign m_tuser  = out_run_end_q;

	assign load = head_valid && (!out_valid_q || m_tready);
	assign pop  = load && idx_q == last_idx;

	// pick the byte at the current position of the head job
	always_comb begin
		cur_byte = crc_q;
		covered  = 1'b0;
		if (head.is_hdr) begin
			last_idx = head.with_crc ? HDR_CRC : HDR_SEQ;
			covered  = idx_q inside {[HDR_TYPE:HDR_SEQ]};
			case (idx_q)
				HDR_SYNC1:  cur_byte = cfg.sync_first;
				HDR_SYNC2:  cur_byte = cfg.sync_second;
				HDR_TYPE:   cur_byte = cfg.frame_type;
				HDR_LEN_LO: cur_byte = head.word[7:0];
				HDR_LEN_HI: cur_byte = head.word[15:8];
				HDR_SEQ:    cur_byte = head.seq;
				default:    cur_byte = crc_q;
			endcase
		end else begin
			last_idx = head.with_crc ? DAT_CRC : DAT_HI;
			covered  = idx_q inside {DAT_LO, DAT_HI};
			case (idx_q)
				DAT_LO:  cur_byte = head.word[7:0];
				DAT_HI:  cur_byte = head.word[15:8];
				default: cur_byte = crc_q;
			endcase
		end
		cur_crc = head.with_crc && idx_q == last_idx;
	end

	// step through the job and fold covered bytes into the CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= pop ? 3'd0 : idx_q + 3'd1;
				if (head.is_hdr && idx_q == HDR_SYNC1) begin
					crc_q <= CRC_INIT;
				end else if (covered) begin
					crc_q <= crc8_add(crc_q, cur_byte);
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q      <= cur_byte;
			out_frame_end_q <= cur_crc;
			out_run_end_q   <= idx_q == last_idx;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sample_frame_encoder_crc8.sv */
// Sample frame encoder: sync, type, length, sequence, samples, CRC-8/SMBUS byte stream.
// An item's first byte passes the job queue and then the output register before it is shown.
// Output runs at one byte per cycle while m_tready is high; a sample is 2 bytes (3 with CRC),
// a start 6 or 7; the 2-entry job queue takes new items until full while earlier ones are serialised.
// Reset (arst_n low) clears frame state, sequence number and queue; registers take defaults.
// Depends on sfe_pkg, sfe_regs, sfe_front, sfe_queue and sfe_back.
`default_nettype none

module sample_frame_encoder_crc8 #(
	parameter int MAX_SAMPLES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [15:0] sample_count, [31:16] sample_value
	input  wire logic        s_tuser,  // [0] cmd
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // [7:0] out_byte
	output logic             m_tlast,  // frame_end
	output logic             m_tuser,  // [0] run_end
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import sfe_pkg::*;

	sfe_cfg_t cfg;
	sfe_cmd_t push_data;
	sfe_cmd_t head;
	logic     push;
	logic     q_full;
	logic     pop;
	logic     head_valid;

	sfe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfe_front #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	sfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	sfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.cfg        (cfg),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

`default_nettype wire

/* rtl/core/sfe_checker.sv */
// Port-level checks for the sample frame encoder, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module sfe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast,
	input wire logic       m_tuser,
	input wire logic       pready
);

	// hold a stalled beat
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("stalled output beat withdrawn");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("stalled output beat changed");

	// a CRC byte always closes the run of its item
	a_crc_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("CRC byte not marked as end of run");

	// the register port never waits
	a_pready: assert property (@(posedge clk) pready)
		else $error("pready dropped");

endmodule

bind sample_frame_encoder_crc8 sfe_checker u_sfe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser),
	.pready   (pready)
);

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for sample_frame_encoder_crc8: streams start and sample beats,
// predicts every output byte of each frame and checks it beat by beat.
// Depends on sfe_pkg and the encoder RTL; nothing else.
`timescale 1ns / 100ps

module tb;

	localparam int MAX_SAMPLES   = 1024;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 1000;
	localparam int MAX_REPORTS   = 10;

	// one byte of the encoded stream as it should leave the block
	typedef struct {
		logic [7:0] data;
		logic       frame_end;
		logic       run_end;
	} enc_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// encoder state as predicted
	logic [7:0]  cfg_regs [3];
	logic [7:0]  seq_next;
	logic [7:0]  crc_run;
	logic [15:0] samples_due;
	logic        discarding;

	enc_byte_t   bytes_due [$];
	int          errors = 0;
	bit          steady = 1'b0;

	sample_frame_encoder_crc8 #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// count failures, print only the first few
	function automatic void mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (errors < MAX_REPORTS) begin
			$display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
		end
		errors++;
	endfunction

	// CRC-8/SMBUS, one byte folded in msb first
	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] r;
		r = crc ^ b;
		repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? sfe_pkg::CRC_POLY : 8'h00);
		return r;
	endfunction

	// advance the predicted state by one accepted beat and queue the bytes it causes
	function automatic void encode_item(input logic cmd, input logic [15:0] count,
			input logic [15:0] value);
		logic [7:0]  vals [7];
		logic [15:0] blen;
		int          n;
		int          fold_from;
		int          i;
		bit          closes;
		enc_byte_t   b;
		n = 0;
		fold_from = 0;
		closes = 1'b0;
		if (cmd == sfe_pkg::ITEM_START) begin
			samples_due = count;
			if (count > MAX_SAMPLES) begin
				discarding = 1'b1;
				return;
			end
			discarding = 1'b0;
			blen = {count[14:0], 1'b0};
			crc_run = sfe_pkg::CRC_INIT;
			vals[0] = cfg_regs[sfe_pkg::REG_SYNC_FIRST];
			vals[1] = cfg_regs[sfe_pkg::REG_SYNC_SECOND];
			vals[2] = cfg_regs[sfe_pkg::REG_FRAME_TYPE];
			vals[3] = blen[7:0];
			vals[4] = blen[15:8];
			vals[5] = seq_next;
			n = 6;
			fold_from = 2;
			seq_next = seq_next + 8'd1;
			closes = (count == 16'd0);
		end else begin
			if (samples_due == 16'd0) return;
			samples_due = samples_due - 16'd1;
			if (discarding) begin
				if (samples_due == 16'd0) discarding = 1'b0;
				return;
			end
			vals[0] = value[7:0];
			vals[1] = value[15:8];
			n = 2;
			closes = (samples_due == 16'd0);
		end
		for (i = fold_from; i < n; i++) crc_run = crc_fold(crc_run, vals[i]);
		if (closes) begin
			vals[n] = crc_run;
			n++;
		end
		for (i = 0; i < n; i++) begin
			b.data = vals[i];
			b.frame_end = closes && (i == n - 1);
			b.run_end = (i == n - 1);
			bytes_due.push_back(b);
		end
	endfunction

	// compare one output beat against the oldest queued byte
	task automatic check_byte();
		enc_byte_t want;
		if (bytes_due.size() == 0) begin
			mismatch("byte with nothing due", 'x, 32'(m_tdata));
		end else begin
			want = bytes_due.pop_front();
			if (m_tdata !== want.data)
				mismatch("out_byte", 32'(want.data), 32'(m_tdata));
			if (m_tlast !== want.frame_end)
				mismatch("frame_end", 32'(want.frame_end), 32'(m_tlast));
			if (m_tuser !== want.run_end)
				mismatch("run_end", 32'(want.run_end), 32'(m_tuser));
		end
	endtask

	// check output beats and stall the receiver at random
	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) check_byte();
		m_tready <= steady || ($urandom_range(99, 0) >= 37);
	end

	// end the run when no beat moves on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	// drive one beat on the slave side, idling first at random
	task automatic send_item(input logic cmd, input logic [15:0] count,
			input logic [15:0] value);
		int gap;
		gap = 0;
		if (!steady) begin
			while (gap < 6 && $urandom_range(99, 0) < 37) gap++;
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {value, count};
		do @(posedge clk); while (s_tready !== 1'b1);
		encode_item(cmd, count, value);
	endtask

	task automatic start_frame(input logic [15:0] count);
		send_item(sfe_pkg::ITEM_START, count, 16'($urandom));
	endtask

	task automatic send_sample(input logic [15:0] value);
		send_item(sfe_pkg::ITEM_SAMPLE, 16'($urandom), value);
	endtask

	// hold the sender until every due byte is out and the block has settled
	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		while (bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register transfer: setup phase, access phase, then an idle phase
	task automatic apb_access(input logic wr, input logic [1:0] idx,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(input logic [1:0] idx, input logic [7:0] want);
		logic [31:0] rd;
		apb_access(1'b0, idx, '0, rd);
		if (rd !== {24'h0, want}) mismatch("register read", {24'h0, want}, rd);
	endtask

	// write a register (junk in the unused upper bits), mirror it and read it back
	task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
		logic [31:0] rd;
		apb_access(1'b1, idx, {24'($urandom), val}, rd);
		cfg_regs[idx] = val;
		check_reg(idx, val);
	endtask

	task automatic set_all_regs(input logic [7:0] first, input logic [7:0] second,
			input logic [7:0] ftype);
		drain_outputs();
		write_cfg(sfe_pkg::REG_SYNC_FIRST, first);
		write_cfg(sfe_pkg::REG_SYNC_SECOND, second);
		write_cfg(sfe_pkg::REG_FRAME_TYPE, ftype);
	endtask

	// mostly complete frames of random samples, plus abandoned, oversized and stray beats
	task automatic random_traffic(input int budget);
		int sent;
		int pick;
		int count;
		int k;
		int n;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(99, 0);
			if (pick < 75) begin
				k = $urandom_range(99, 0);
				count = (k < 60) ? $urandom_range(4, 0) :
					(k < 90) ? $urandom_range(16, 5) : $urandom_range(40, 17);
				start_frame(16'(count));
				for (n = 0; n < count; n++) send_sample(16'($urandom));
				sent += count + 1;
			end else if (pick < 85) begin
				count = $urandom_range(16, 1);
				start_frame(16'(count));
				k = $urandom_range(count - 1, 0);
				for (n = 0; n < k; n++) send_sample(16'($urandom));
				sent += k + 1;
			end else if (pick < 93) begin
				start_frame(16'($urandom_range(65535, MAX_SAMPLES + 1)));
				k = $urandom_range(3, 0);
				for (n = 0; n < k; n++) send_sample(16'($urandom));
				sent += 1;
			end else begin
				k = $urandom_range(3, 1);
				for (n = 0; n < k; n++) send_sample(16'($urandom));
			end
		end
	endtask

	// reset values, a stray sample, and the shortest frames with extreme samples
	task automatic test_reset_defaults();
		check_reg(sfe_pkg::REG_SYNC_FIRST, sfe_pkg::SYNC_FIRST_RST);
		check_reg(sfe_pkg::REG_SYNC_SECOND, sfe_pkg::SYNC_SECOND_RST);
		check_reg(sfe_pkg::REG_FRAME_TYPE, sfe_pkg::FRAME_TYPE_RST);
		send_sample(16'h1234);
		start_frame(16'd0);
		start_frame(16'd1);
		send_sample(16'h0000);
		start_frame(16'd2);
		send_sample(16'hFFFF);
		send_sample(16'h8001);
	endtask

	// largest legal count, just over the limit, full-scale count, abandoning in between
	task automatic test_size_limits();
		start_frame(16'(MAX_SAMPLES));
		send_sample(16'($urandom));
		send_sample(16'($urandom));
		start_frame(16'(MAX_SAMPLES + 1));
		send_sample(16'($urandom));
		send_sample(16'($urandom));
		start_frame(16'hFFFF);
		send_sample(16'($urandom));
		drain_outputs();
		start_frame(16'd3);
		send_sample(16'($urandom));
		send_sample(16'($urandom));
		send_sample(16'($urandom));
		send_sample(16'($urandom));
	endtask

	// let an oversized frame swallow a run of samples, then check the stream recovers
	task automatic test_drop_and_recover();
		int i;
		start_frame(16'(MAX_SAMPLES + 1));
		for (i = 0; i < 12; i++) send_sample(16'($urandom));
		start_frame(16'd1);
		send_sample(16'($urandom));
		send_sample(16'($urandom));
	endtask

	task automatic test_register_settings();
		set_all_regs(8'h00, 8'h00, 8'h00);
		random_traffic(35);
		set_all_regs(8'hFF, 8'hFF, 8'hFF);
		random_traffic(35);
		set_all_regs(8'($urandom), 8'($urandom), 8'($urandom));
		random_traffic(35);
	endtask

	// a stretch with no idling on either side, then random idling again
	task automatic test_random_frames();
		steady = 1'b1;
		random_traffic(65);
		steady = 1'b0;
		random_traffic(140);
	endtask

	initial begin : main
		cfg_regs[sfe_pkg::REG_SYNC_FIRST] = sfe_pkg::SYNC_FIRST_RST;
		cfg_regs[sfe_pkg::REG_SYNC_SECOND] = sfe_pkg::SYNC_SECOND_RST;
		cfg_regs[sfe_pkg::REG_FRAME_TYPE] = sfe_pkg::FRAME_TYPE_RST;
		seq_next = '0;
		crc_run = '0;
		samples_due = '0;
		discarding = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_size_limits();
		test_drop_and_recover();
		test_register_settings();
		test_random_frames();
		drain_outputs();
		if (errors == 0 && bytes_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
